>>> src/tmd_pkg.sv
// Shared types and codes for the topic/message deframer.
`timescale 1ns / 1ps

package tmd_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned TmdQueueDepth = 2;

  localparam int unsigned LenWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  typedef enum logic [1:0] {
    KIND_DATA        = 2'd0,
    KIND_PEER_CLOSED = 2'd1,
    KIND_TIMEOUT     = 2'd2,
    KIND_RX_ERROR    = 2'd3
  } item_kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PEER_CLOSED = 3'd1,
    ST_TIMEOUT     = 3'd2,
    ST_RX_ERROR    = 3'd3,
    ST_TOO_LARGE   = 3'd4
  } frame_status_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic                 is_event;
    frame_status_e        status;
    logic [ByteWidth-1:0] data;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [ByteWidth-1:0] payload_byte;
    logic                 has_byte;
    logic                 in_message;
    logic                 last_of_section;
    logic                 frame_done;
    frame_status_e        frame_status;
  } res_t;

  // Queue handshake toward the back part
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

>>> src/tmd_front.sv
// Front stage: accept input requests and classify them as data or link event.
`timescale 1ns / 1ps

module tmd_front
  import tmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  item_kind_e in_kind_i,
  input  logic [7:0] in_data_i,
  output logic       push_o,
  output cmd_t       push_cmd_o,
  input  logic       q_full_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  assign push_o     = valid_q && !q_full_i;
  assign in_ready_o = !valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_cmd_o = cmd_q;

  always_comb begin
    cmd_d.data     = in_data_i;
    cmd_d.is_event = (in_kind_i != KIND_DATA);
    unique case (in_kind_i)
      KIND_DATA:        cmd_d.status = ST_OK;
      KIND_PEER_CLOSED: cmd_d.status = ST_PEER_CLOSED;
      KIND_TIMEOUT:     cmd_d.status = ST_TIMEOUT;
      KIND_RX_ERROR:    cmd_d.status = ST_RX_ERROR;
      default:          cmd_d.status = ST_OK;
    endcase
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

>>> src/tmd_queue.sv
// Short request queue between front and back.
`timescale 1ns / 1ps

module tmd_queue
  import tmd_pkg::*;
#(
  parameter int unsigned Depth = TmdQueueDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_cmd_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  cmd_t                mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == FullCnt);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Front must never push into a full queue, and back must pop only a filled one
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i || pop_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_o.valid)
    else $error("pop from empty queue");

endmodule

>>> src/tmd_back.sv
// Back part: frame parser with length checks and a registered result stage.
`timescale 1ns / 1ps

module tmd_back
  import tmd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q_head_t             head_i,
  output logic                pop_o,
  input  logic [LenWidth-1:0] max_topic_i,
  input  logic [LenWidth-1:0] max_msg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output res_t                out_res_o
);

  typedef enum logic [1:0] {
    PH_TOPIC_LEN  = 2'd0,
    PH_TOPIC_BODY = 2'd1,
    PH_MSG_LEN    = 2'd2,
    PH_MSG_BODY   = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [1:0]          idx_q, idx_d;
  logic [LenWidth-1:0] acc_q, acc_d;
  logic [LenWidth-1:0] rem_q, rem_d;
  logic                out_valid_q;
  res_t                out_res_q;

  logic                produce;
  res_t                res;
  logic [LenWidth-1:0] acc_full, limit, rem_dec;
  logic                is_msg, last;

  assign pop_o       = head_i.valid && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  assign acc_full = {acc_q[LenWidth-ByteWidth-1:0], head_i.cmd.data};
  assign is_msg   = (phase_q == PH_MSG_LEN) || (phase_q == PH_MSG_BODY);
  assign limit    = is_msg ? max_msg_i : max_topic_i;
  assign rem_dec  = rem_q - LenWidth'(rem_q != '0);
  assign last     = (rem_dec == '0);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    produce = 1'b0;
    res     = '0;
    if (head_i.cmd.is_event) begin
      // Drop partial progress and report the event
      phase_d          = PH_TOPIC_LEN;
      idx_d            = '0;
      acc_d            = '0;
      rem_d            = '0;
      produce          = 1'b1;
      res.frame_done   = 1'b1;
      res.frame_status = head_i.cmd.status;
    end else begin
      unique case (phase_q)
        PH_TOPIC_LEN, PH_MSG_LEN: begin
          if (idx_q != 2'd3) begin
            idx_d = idx_q + 2'd1;
            acc_d = acc_full;
          end else begin
            idx_d = '0;
            acc_d = '0;
            if (acc_full > limit) begin
              phase_d          = PH_TOPIC_LEN;
              rem_d            = '0;
              produce          = 1'b1;
              res.frame_done   = 1'b1;
              res.frame_status = ST_TOO_LARGE;
            end else if (acc_full == '0) begin
              phase_d = PH_MSG_LEN;
              if (is_msg) begin
                phase_d        = PH_TOPIC_LEN;
                rem_d          = '0;
                produce        = 1'b1;
                res.frame_done = 1'b1;
              end
            end else begin
              rem_d   = acc_full;
              phase_d = is_msg ? PH_MSG_BODY : PH_TOPIC_BODY;
            end
          end
        end
        PH_TOPIC_BODY, PH_MSG_BODY: begin
          rem_d               = rem_dec;
          produce             = 1'b1;
          res.payload_byte    = head_i.cmd.data;
          res.has_byte        = 1'b1;
          res.in_message      = is_msg;
          res.last_of_section = last;
          if (last) begin
            phase_d = is_msg ? PH_TOPIC_LEN : PH_MSG_LEN;
            idx_d   = '0;
            acc_d   = '0;
            res.frame_done = is_msg;
          end
        end
        default: begin
          phase_d = PH_TOPIC_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TOPIC_LEN;
      idx_q       <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      out_valid_q <= produce;
      out_res_q   <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A body phase always has bytes left to take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TOPIC_BODY || phase_q == PH_MSG_BODY) |-> rem_q != '0)
    else $error("body phase with no bytes remaining");
  // A result without a body byte always closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.has_byte |-> out_res_q.frame_done)
    else $error("empty result that does not end the frame");
  // A successful frame end only comes on a message byte or an empty message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.frame_done && out_res_q.has_byte |->
      out_res_q.in_message && out_res_q.last_of_section)
    else $error("frame ended on a byte that is not the last message byte");

endmodule

>>> src/topic_message_deframer_unit.sv
// Top level of the topic/message deframer: config registers, front, queue and back.
`timescale 1ns / 1ps

//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: data_byte; tuser: item_kind
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: payload_byte; tlast: frame_done;
//           |           |                              | tuser: has_byte, in_message,
//           |           |                              |        last_of_section, frame_status
//  cfg      | in        | cfg_we_i (no back-pressure)  | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while the result stream is not stalled. A request passes
// the front register, the queue and the result register.
// The back part handles each byte in one combinational parser step (one 32-bit compare
// and one 32-bit decrement per byte).
// Reset clears the parser to await a topic length and sets both maximum lengths to all ones.
// A stalled output holds the back part; the queue then fills and s_axis_tready falls.

module topic_message_deframer_unit
  import tmd_pkg::*;
#(
  parameter int unsigned QueueDepth = TmdQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]          s_axis_tuser,   // [1:0] item_kind
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] payload_byte
  output logic                m_axis_tlast,   // frame_done
  output logic [5:0]          m_axis_tuser,   // [0] has_byte, [1] in_message,
                                              // [2] last_of_section, [5:3] frame_status
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [LenWidth-1:0] cfg_wdata_i
);

  localparam logic RegMaxTopic = 1'b0;
  localparam logic RegMaxMsg   = 1'b1;

  logic [LenWidth-1:0] max_topic_q, max_msg_q;

  logic    push, q_full, pop;
  cmd_t    push_cmd;
  q_head_t head;
  res_t    out_res;

  // Hold the length limits; writes must come only while the block is idle, which it does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_topic_q <= '1;
      max_msg_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxTopic: max_topic_q <= cfg_wdata_i;
        RegMaxMsg:   max_msg_q   <= cfg_wdata_i;
        default:     max_topic_q <= max_topic_q;
      endcase
    end
  end

  // Classify each request as a data byte or a link event
  tmd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (item_kind_e'(s_axis_tuser)),
    .in_data_i  (s_axis_tdata),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .q_full_i   (q_full)
  );

  // Decouple classification from parsing so each side stalls on its own
  tmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head)
  );

  // Advance the frame parser and register its result
  tmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .max_topic_i (max_topic_q),
    .max_msg_i   (max_msg_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tlast = out_res.frame_done;
  assign m_axis_tuser = {out_res.frame_status, out_res.last_of_section,
                         out_res.in_message, out_res.has_byte};

endmodule
